// File: rtl/prra_pkg.sv
// Shared types, codes and sizes for the priority round-robin channel arbiter.
// Used by every module under rtl/; depends on nothing.
package prra_pkg;

  localparam int NUM_LINKS        = 8;
  localparam int MAX_FRAME        = 256;
  localparam int DEFAULT_PRIORITY = 128;

  localparam int LIDX_W     = $clog2(NUM_LINKS);
  localparam int LEN_W      = $clog2(MAX_FRAME + 1);
  localparam int KIND_W     = 3;
  localparam int ID_W       = 8;
  localparam int PRI_W      = 8;
  localparam int FLEN_W     = 12;
  localparam int STATUS_W   = 2;
  localparam int LINK_OUT_W = 3;
  localparam int GLEN_W     = 9;

  typedef logic [LIDX_W-1:0]   lidx_t;
  typedef logic [PRI_W-1:0]    pri_t;
  typedef logic [LEN_W-1:0]    slen_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_REGISTER   = 3'd0;
  localparam kind_t KIND_UNREGISTER = 3'd1;
  localparam kind_t KIND_SEIZE      = 3'd2;
  localparam kind_t KIND_RELEASE    = 3'd3;
  localparam kind_t KIND_TICK       = 3'd4;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_BAD  = 2'd1;
  localparam status_t ST_BUSY = 2'd2;

  // One slot as seen through the read port.
  typedef struct packed {
    logic  active;
    logic  pending;
    pri_t  pri;
    slen_t len;
  } slot_rd_t;

  // Per-field write enables for the slot at the current index.
  typedef struct packed {
    logic  active_we;
    logic  active;
    logic  pending_we;
    logic  pending;
    logic  pri_we;
    pri_t  pri;
    logic  len_we;
    slen_t len;
  } slot_wr_t;

endpackage

// File: rtl/priority_round_robin_channel_arbiter.sv
// Priority round-robin channel arbiter: one transmit channel shared by link slots.
// Input channel (in_valid/in_stall) takes one request: register, unregister,
// seize, release or tick. Each request yields exactly one result on the output
// channel (out_valid/out_stall): status, assigned slot and any channel grant.
// Unregister, seize, plain release and busy tick go straight to the result;
// register scans for a free slot, and a grant attempt makes up to two passes:
// one for the top priority and one round-robin pass from the slot after the
// last grant, one slot per cycle through the shared comparator and the single
// slot-file port.
// in_stall is high while a request is in work. A finished result sits in the
// output register; the next request is accepted while it waits, and a
// further result holds in its final state until the register frees up.
// Synchronous active-low reset marks every slot inactive and not pending,
// leaves the channel idle and sets the last grant to slot 0.
// Depends on prra_pkg, prra_slot_file and prra_cmp.
module priority_round_robin_channel_arbiter import prra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [ID_W-1:0]       in_link_id,
  input  logic [PRI_W-1:0]      in_priority_req,
  input  logic [FLEN_W-1:0]     in_frame_len,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [LINK_OUT_W-1:0] out_assigned_link,
  output logic                  out_grant_valid,
  output logic [LINK_OUT_W-1:0] out_grant_link,
  output logic [GLEN_W-1:0]     out_grant_len
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_MAX  = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam lidx_t LAST_IDX = LIDX_W'(NUM_LINKS - 1);

  logic [2:0] state_r, state_nxt;
  lidx_t      idx_r, idx_nxt;
  kind_t      kind_r;
  logic       id_ok_r, len_ok_r;
  pri_t       pri_req_r;
  slen_t      len_r;
  pri_t       best_r, best_nxt;
  logic       any_r, any_nxt;
  lidx_t      last_r, last_nxt;
  logic       owner_valid_r, owner_valid_nxt;
  lidx_t      owner_r, owner_nxt;

  status_t    res_status_r, res_status_nxt;
  lidx_t      res_assigned_r, res_assigned_nxt;
  logic       res_gvalid_r, res_gvalid_nxt;
  lidx_t      res_glink_r, res_glink_nxt;
  slen_t      res_glen_r, res_glen_nxt;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [LINK_OUT_W-1:0] out_assigned_r;
  logic                  out_gvalid_r;
  logic [LINK_OUT_W-1:0] out_glink_r;
  logic [GLEN_W-1:0]     out_glen_r;

  logic     in_acc;
  logic     load_out;
  slot_wr_t wr;
  slot_rd_t rd;
  logic     take;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  prra_slot_file u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .idx   (idx_r),
    .wr    (wr),
    .rd    (rd)
  );

  prra_cmp u_cmp (
    .eligible   (rd.active && rd.pending),
    .pri        (rd.pri),
    .best       (best_r),
    .any        (any_r),
    .match_mode (state_r == S_PICK),
    .take       (take)
  );

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    best_nxt         = best_r;
    any_nxt          = any_r;
    last_nxt         = last_r;
    owner_valid_nxt  = owner_valid_r;
    owner_nxt        = owner_r;
    res_status_nxt   = res_status_r;
    res_assigned_nxt = res_assigned_r;
    res_gvalid_nxt   = res_gvalid_r;
    res_glink_nxt    = res_glink_r;
    res_glen_nxt     = res_glen_r;
    wr               = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt        = S_EXEC;
          idx_nxt          = (in_kind == KIND_REGISTER) ? '0 : LIDX_W'(in_link_id);
          res_status_nxt   = ST_OK;
          res_assigned_nxt = '0;
          res_gvalid_nxt   = 1'b0;
          res_glink_nxt    = '0;
          res_glen_nxt     = '0;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (kind_r)
          KIND_REGISTER: begin
            state_nxt = S_FREE;
          end
          KIND_UNREGISTER: begin
            if (!id_ok_r) begin
              res_status_nxt = ST_BAD;
            end else begin
              wr.active_we = 1'b1;
              wr.active    = 1'b0;
            end
          end
          KIND_SEIZE: begin
            if (!id_ok_r || !len_ok_r) begin
              res_status_nxt = ST_BAD;
            end else if (!rd.active || rd.pending) begin
              res_status_nxt = ST_BUSY;
            end else begin
              wr.pending_we = 1'b1;
              wr.pending    = 1'b1;
              wr.pri_we     = 1'b1;
              wr.pri        = pri_req_r;
              wr.len_we     = 1'b1;
              wr.len        = len_r;
            end
          end
          KIND_RELEASE: begin
            if (!id_ok_r) begin
              res_status_nxt = ST_BAD;
            end else begin
              wr.pending_we = 1'b1;
              wr.pending    = 1'b0;
              wr.len_we     = 1'b1;
              wr.len        = '0;
              // Owner gave the channel back: arbitrate at once.
              if (owner_valid_r && (owner_r == idx_r)) begin
                owner_valid_nxt = 1'b0;
                idx_nxt         = '0;
                any_nxt         = 1'b0;
                best_nxt        = '0;
                state_nxt       = S_MAX;
              end
            end
          end
          KIND_TICK: begin
            if (!owner_valid_r) begin
              idx_nxt   = '0;
              any_nxt   = 1'b0;
              best_nxt  = '0;
              state_nxt = S_MAX;
            end
          end
          default: begin
            res_status_nxt = ST_BAD;
          end
        endcase
      end

      S_FREE: begin
        if (!rd.active) begin
          wr.active_we     = 1'b1;
          wr.active        = 1'b1;
          wr.pending_we    = 1'b1;
          wr.pending       = 1'b0;
          wr.pri_we        = 1'b1;
          wr.pri           = PRI_W'(DEFAULT_PRIORITY);
          wr.len_we        = 1'b1;
          wr.len           = '0;
          res_assigned_nxt = idx_r;
          state_nxt        = S_DONE;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_BUSY;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_MAX: begin
        if (take) begin
          best_nxt = rd.pri;
          any_nxt  = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          if (take || any_r) begin
            // Start the tie-break pass just after the last served link.
            idx_nxt   = (last_r == LAST_IDX) ? '0 : last_r + 1'b1;
            state_nxt = S_PICK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_PICK: begin
        if (take) begin
          wr.pending_we   = 1'b1;
          wr.pending      = 1'b0;
          owner_valid_nxt = 1'b1;
          owner_nxt       = idx_r;
          last_nxt        = idx_r;
          res_gvalid_nxt  = 1'b1;
          res_glink_nxt   = idx_r;
          res_glen_nxt    = rd.len;
          state_nxt       = S_DONE;
        end else begin
          idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        end
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      any_r         <= 1'b0;
      last_r        <= '0;
      owner_valid_r <= 1'b0;
      owner_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      any_r         <= any_nxt;
      last_r        <= last_nxt;
      owner_valid_r <= owner_valid_nxt;
      owner_r       <= owner_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    best_r         <= best_nxt;
    res_status_r   <= res_status_nxt;
    res_assigned_r <= res_assigned_nxt;
    res_gvalid_r   <= res_gvalid_nxt;
    res_glink_r    <= res_glink_nxt;
    res_glen_r     <= res_glen_nxt;
    if (in_acc) begin
      kind_r    <= in_kind;
      id_ok_r   <= (in_link_id < ID_W'(NUM_LINKS));
      len_ok_r  <= (in_frame_len != '0) && (in_frame_len <= FLEN_W'(MAX_FRAME));
      pri_req_r <= in_priority_req;
      len_r     <= LEN_W'(in_frame_len);
    end
    if (load_out) begin
      out_status_r   <= res_status_r;
      out_assigned_r <= LINK_OUT_W'(res_assigned_r);
      out_gvalid_r   <= res_gvalid_r;
      out_glink_r    <= LINK_OUT_W'(res_glink_r);
      out_glen_r     <= GLEN_W'(res_glen_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_link = out_assigned_r;
  assign out_grant_valid   = out_gvalid_r;
  assign out_grant_link    = out_glink_r;
  assign out_grant_len     = out_glen_r;

`ifndef SYNTHESIS
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grant_valid |-> out_status == ST_OK)
    else $error("grant reported with a failing status");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_grant_valid && (out_assigned_link == '0))
    else $error("failed request carries a slot or a grant");

  a_grant_owns: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && res_gvalid_r |=> owner_valid_r && (owner_r == last_r))
    else $error("granted link does not own the channel");

  a_pick_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PICK |-> any_r)
    else $error("tie-break pass entered with no eligible link");
`endif

endmodule

// File: rtl/prra_slot_file.sv
// Link slot state: active and pending flags, priority and frame length.
// One shared index for read and write. Depends on prra_pkg.
module prra_slot_file import prra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  lidx_t    idx,
  input  slot_wr_t wr,
  output slot_rd_t rd
);

  logic [NUM_LINKS-1:0]            active_r;
  logic [NUM_LINKS-1:0]            pending_r;
  logic [NUM_LINKS-1:0][PRI_W-1:0] pri_r;
  logic [NUM_LINKS-1:0][LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      pending_r <= '0;
    end else begin
      if (wr.active_we) begin
        active_r[idx] <= wr.active;
      end
      if (wr.pending_we) begin
        pending_r[idx] <= wr.pending;
      end
    end
  end

  // Priority and length are only read once a seize or register wrote them.
  always_ff @(posedge clk) begin
    if (wr.pri_we) begin
      pri_r[idx] <= wr.pri;
    end
    if (wr.len_we) begin
      len_r[idx] <= wr.len;
    end
  end

  assign rd.active  = active_r[idx];
  assign rd.pending = pending_r[idx];
  assign rd.pri     = pri_r[idx];
  assign rd.len     = len_r[idx];

endmodule

// File: rtl/prra_cmp.sv
// Shared priority comparator used by both arbitration passes.
// Max pass: take a higher priority; pick pass: take an equal one. Depends on prra_pkg.
module prra_cmp import prra_pkg::*; (
  input  logic eligible,
  input  pri_t pri,
  input  pri_t best,
  input  logic any,
  input  logic match_mode,
  output logic take
);

  always_comb begin
    if (match_mode) begin
      take = eligible && (pri == best);
    end else begin
      take = eligible && (!any || (pri > best));
    end
  end

endmodule
